// ----- rtl/core/lru_page_replacement_unit_defines.svh -----
// Assertion macros for the LRU page replacement unit checker.
// Depends on nothing; included by the checker file.
`ifndef LRU_PAGE_REPLACEMENT_UNIT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LPRU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lru page replacement check failed");

// next-cycle implication, disabled during reset
`define LPRU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lru page replacement check failed");

`endif

// ----- rtl/core/lpru_pkg.sv -----
// Package for the LRU page replacement unit: defaults, FSM states, cell control.
// Depends on nothing; used by lpru_cell and lru_page_replacement_unit.
`default_nettype none

package lpru_pkg;

  localparam int unsigned FRAMES_DEF    = 8;
  localparam int unsigned PAGE_BITS_DEF = 16;
  localparam int unsigned CFG_W         = 4;
  localparam int unsigned FIDX_W        = 3;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } lpru_state_e;

  typedef struct packed {
    logic upd;
    logic hit;
  } lpru_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/lpru_cell.sv -----
// One frame cell: resident page, recency rank, and one stage of the scan chain.
// Depends on lpru_pkg; instantiated by lru_page_replacement_unit.
`default_nettype none

module lpru_cell #(
  parameter int unsigned PAGE_BITS = lpru_pkg::PAGE_BITS_DEF,
  parameter int unsigned AGE_W     = 3,
  parameter int unsigned IDX_W     = 3,
  parameter int unsigned FILL_W    = 4,
  parameter int unsigned SLOT      = 0
) (
  input  wire                      clk_i,
  input  lpru_pkg::lpru_ctl_t      ctl_i,
  input  wire  [FILL_W-1:0]        filled_i,
  input  wire  [PAGE_BITS-1:0]     page_i,
  input  wire  [AGE_W-1:0]         oldest_age_i,
  input  wire  [IDX_W-1:0]         slot_i,
  input  wire  [AGE_W-1:0]         hit_age_i,
  input  wire                      prv_hit_i,
  input  wire  [IDX_W-1:0]         prv_hit_idx_i,
  input  wire  [AGE_W-1:0]         prv_hit_age_i,
  input  wire  [IDX_W-1:0]         prv_old_idx_i,
  input  wire  [PAGE_BITS-1:0]     prv_old_page_i,
  output logic                     nxt_hit_o,
  output logic [IDX_W-1:0]         nxt_hit_idx_o,
  output logic [AGE_W-1:0]         nxt_hit_age_o,
  output logic [IDX_W-1:0]         nxt_old_idx_o,
  output logic [PAGE_BITS-1:0]     nxt_old_page_o
);

  localparam logic [IDX_W-1:0]  MY_IDX  = IDX_W'(SLOT);
  localparam logic [FILL_W-1:0] MY_FILL = FILL_W'(SLOT);

  logic [PAGE_BITS-1:0] page_q, page_d;
  logic [AGE_W-1:0]     age_q, age_d;
  logic                 hit_q, hit_d;
  logic [IDX_W-1:0]     hit_idx_q, hit_idx_d;
  logic [AGE_W-1:0]     hit_age_q, hit_age_d;
  logic [IDX_W-1:0]     old_idx_q, old_idx_d;
  logic [PAGE_BITS-1:0] old_page_q, old_page_d;
  logic                 valid;
  logic                 match;
  logic                 oldest;
  logic                 sel;

  assign valid  = filled_i > MY_FILL;
  assign match  = valid && (page_q == page_i);
  assign oldest = valid && (age_q == oldest_age_i);
  assign sel    = slot_i == MY_IDX;

  // merge own compare into the word handed down the chain
  always_comb begin
    hit_d      = prv_hit_i | match;
    hit_idx_d  = match ? MY_IDX : prv_hit_idx_i;
    hit_age_d  = match ? age_q : prv_hit_age_i;
    old_idx_d  = oldest ? MY_IDX : prv_old_idx_i;
    old_page_d = oldest ? page_q : prv_old_page_i;
  end

  always_comb begin
    page_d = page_q;
    age_d  = age_q;
    if (ctl_i.upd) begin
      if (sel) begin
        age_d = '0;
        if (!ctl_i.hit) begin
          page_d = page_i;
        end
      end else if (valid && (!ctl_i.hit || (age_q < hit_age_i))) begin
        age_d = age_q + AGE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    page_q     <= page_d;
    age_q      <= age_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    hit_age_q  <= hit_age_d;
    old_idx_q  <= old_idx_d;
    old_page_q <= old_page_d;
  end

  assign nxt_hit_o      = hit_q;
  assign nxt_hit_idx_o  = hit_idx_q;
  assign nxt_hit_age_o  = hit_age_q;
  assign nxt_old_idx_o  = old_idx_q;
  assign nxt_old_page_o = old_page_q;

endmodule

`default_nettype wire

// ----- rtl/core/lru_page_replacement_unit.sv -----
// LRU page replacement unit: top level with control FSM and the row of frame cells.
// Depends on lpru_pkg and lpru_cell.
// Usage:
//   Present a page on page_number_i with start_i high while busy_o is low; the
//   word is taken at that clock edge. The reference then walks the row of
//   FRAMES cells, one cell per cycle, gathering the matching frame and the
//   least recently used frame, and the update state then writes pages and ranks.
//   The result is on hit_o, frame_index_o, evicted_o and evicted_page_o,
//   marked by done_o, which is high for exactly one cycle and is registered
//   from the update state. A new word may be started in the done_o cycle.
//   The receiver cannot stall: every result is delivered in its done_o cycle.
//   cfg_we_i with cfg_wdata_i writes frames_in_use (0 acts as 1, values above
//   FRAMES act as FRAMES); write it only while the unit is idle.
//   Reset empties all frames and sets frames_in_use to 8; the unit is idle and
//   ready at the first edge after reset is released.
`default_nettype none

module lru_page_replacement_unit #(
  parameter int unsigned FRAMES    = lpru_pkg::FRAMES_DEF,
  parameter int unsigned PAGE_BITS = lpru_pkg::PAGE_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  output logic                         busy_o,
  input  wire  [PAGE_BITS-1:0]         page_number_i,
  input  wire                          cfg_we_i,
  input  wire  [lpru_pkg::CFG_W-1:0]   cfg_wdata_i,
  output logic                         done_o,
  output logic                         hit_o,
  output logic [lpru_pkg::FIDX_W-1:0]  frame_index_o,
  output logic                         evicted_o,
  output logic [PAGE_BITS-1:0]         evicted_page_o
);

  localparam int unsigned IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned AGE_W  = IDX_W;
  localparam int unsigned FILL_W = $clog2(FRAMES + 1);
  localparam int unsigned CW     = (FILL_W > lpru_pkg::CFG_W) ? FILL_W : lpru_pkg::CFG_W;

  lpru_pkg::lpru_state_e       state_q, state_d;
  logic [IDX_W-1:0]            cnt_q, cnt_d;
  logic [FILL_W-1:0]           filled_q, filled_d;
  logic [lpru_pkg::CFG_W-1:0]  limit_q;
  logic [PAGE_BITS-1:0]        page_q;
  logic                        done_q;
  logic                        hit_q;
  logic [lpru_pkg::FIDX_W-1:0] fidx_q;
  logic                        evict_q;
  logic [PAGE_BITS-1:0]        evict_page_q;

  logic                        accept;
  logic                        upd;
  lpru_pkg::lpru_ctl_t         ctl;
  logic [CW-1:0]               cfg_ext;
  logic [CW-1:0]               lim;
  logic                        fill;
  logic                        evict;
  logic [IDX_W-1:0]            slot;
  logic [IDX_W+2:0]            slot_ext;
  logic [AGE_W-1:0]            oldest_age;

  logic                        hit_w      [FRAMES+1];
  logic [IDX_W-1:0]            hit_idx_w  [FRAMES+1];
  logic [AGE_W-1:0]            hit_age_w  [FRAMES+1];
  logic [IDX_W-1:0]            old_idx_w  [FRAMES+1];
  logic [PAGE_BITS-1:0]        old_page_w [FRAMES+1];

  assign accept = start_i && (state_q == lpru_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    upd     = 1'b0;
    case (state_q)
      lpru_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (start_i) begin
          state_d = lpru_pkg::ST_SCAN;
        end
      end
      lpru_pkg::ST_SCAN: begin
        cnt_d = cnt_q + IDX_W'(1);
        if (cnt_q == IDX_W'(FRAMES - 1)) begin
          state_d = lpru_pkg::ST_UPDATE;
        end
      end
      lpru_pkg::ST_UPDATE: begin
        upd     = 1'b1;
        state_d = lpru_pkg::ST_IDLE;
      end
      default: begin
        state_d = lpru_pkg::ST_IDLE;
      end
    endcase
  end

  assign cfg_ext    = CW'(limit_q);
  assign lim        = (cfg_ext == '0) ? CW'(1) :
                      (cfg_ext > CW'(FRAMES)) ? CW'(FRAMES) : cfg_ext;
  assign oldest_age = AGE_W'(filled_q - FILL_W'(1));
  assign fill       = !hit_w[FRAMES] && (CW'(filled_q) < lim);
  assign evict      = !hit_w[FRAMES] && !fill;
  assign slot       = hit_w[FRAMES] ? hit_idx_w[FRAMES] :
                      fill ? IDX_W'(filled_q) : old_idx_w[FRAMES];
  assign slot_ext   = {3'b000, slot};
  assign filled_d   = (upd && fill) ? filled_q + FILL_W'(1) : filled_q;

  assign ctl.upd = upd;
  assign ctl.hit = hit_w[FRAMES];

  assign hit_w[0]      = 1'b0;
  assign hit_idx_w[0]  = '0;
  assign hit_age_w[0]  = '0;
  assign old_idx_w[0]  = '0;
  assign old_page_w[0] = '0;

  for (genvar k = 0; k < FRAMES; k++) begin : g_cell
    lpru_cell #(
      .PAGE_BITS (PAGE_BITS),
      .AGE_W     (AGE_W),
      .IDX_W     (IDX_W),
      .FILL_W    (FILL_W),
      .SLOT      (k)
    ) u_cell (
      .clk_i          (clk_i),
      .ctl_i          (ctl),
      .filled_i       (filled_q),
      .page_i         (page_q),
      .oldest_age_i   (oldest_age),
      .slot_i         (slot),
      .hit_age_i      (hit_age_w[FRAMES]),
      .prv_hit_i      (hit_w[k]),
      .prv_hit_idx_i  (hit_idx_w[k]),
      .prv_hit_age_i  (hit_age_w[k]),
      .prv_old_idx_i  (old_idx_w[k]),
      .prv_old_page_i (old_page_w[k]),
      .nxt_hit_o      (hit_w[k+1]),
      .nxt_hit_idx_o  (hit_idx_w[k+1]),
      .nxt_hit_age_o  (hit_age_w[k+1]),
      .nxt_old_idx_o  (old_idx_w[k+1]),
      .nxt_old_page_o (old_page_w[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lpru_pkg::ST_IDLE;
      cnt_q    <= '0;
      filled_q <= '0;
      limit_q  <= lpru_pkg::CFG_RESET;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      filled_q <= filled_d;
      done_q   <= upd;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      page_q <= page_number_i;
    end
    if (upd) begin
      hit_q        <= hit_w[FRAMES];
      fidx_q       <= slot_ext[lpru_pkg::FIDX_W-1:0];
      evict_q      <= evict;
      evict_page_q <= evict ? old_page_w[FRAMES] : '0;
    end
  end

  assign busy_o         = state_q != lpru_pkg::ST_IDLE;
  assign done_o         = done_q;
  assign hit_o          = hit_q;
  assign frame_index_o  = fidx_q;
  assign evicted_o      = evict_q;
  assign evicted_page_o = evict_page_q;

endmodule

`default_nettype wire

// ----- rtl/core/lpru_chk.sv -----
// Port-level checker for the LRU page replacement unit, bound to the top level.
// Depends on lru_page_replacement_unit_defines.svh and lpru_pkg.
`default_nettype none
`include "lru_page_replacement_unit_defines.svh"

module lpru_chk #(
  parameter int unsigned PAGE_BITS = lpru_pkg::PAGE_BITS_DEF
) (
  input wire                         clk_i,
  input wire                         rst_ni,
  input wire                         start_i,
  input wire                         busy_o,
  input wire                         done_o,
  input wire                         hit_o,
  input wire                         evicted_o,
  input wire [PAGE_BITS-1:0]         evicted_page_o
);

  `LPRU_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o)
  `LPRU_ASSERT_NOW(a_hit_no_evict, done_o, !(hit_o && evicted_o))
  `LPRU_ASSERT_NOW(a_evpage_zero, done_o && !evicted_o, evicted_page_o == '0)
  `LPRU_ASSERT_NEXT(a_done_single, done_o, !done_o)
  `LPRU_ASSERT_NOW(a_done_idle, done_o, !busy_o)

endmodule

bind lru_page_replacement_unit lpru_chk #(
  .PAGE_BITS (PAGE_BITS)
) u_lpru_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .hit_o          (hit_o),
  .evicted_o      (evicted_o),
  .evicted_page_o (evicted_page_o)
);

`default_nettype wire

// ----- dv/lru_page_replacement_unit_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for lru_page_replacement_unit: directed table, then random references.
// Tracks resident pages and recency ranks alongside the unit; needs only lpru_pkg and the RTL.

module lru_page_replacement_unit_test;

  localparam int unsigned FRAMES     = lpru_pkg::FRAMES_DEF;
  localparam int unsigned PAGE_W     = lpru_pkg::PAGE_BITS_DEF;
  localparam int unsigned IDLE_LIMIT = 400;
  localparam int unsigned PLAN_ROWS  = 24;
  localparam int unsigned PHASES     = 8;
  localparam int unsigned PHASE_REFS = 50;

  typedef struct packed {
    logic                        hit;
    logic [lpru_pkg::FIDX_W-1:0] frame_index;
    logic                        evicted;
    logic [PAGE_W-1:0]           evicted_page;
  } ref_outcome_t;

  typedef enum logic {
    ROW_PAGE,
    ROW_LIMIT
  } row_kind_e;

  typedef struct packed {
    row_kind_e                   kind;
    logic [PAGE_W-1:0]           value;
    logic                        pinned;
    logic                        hit;
    logic [lpru_pkg::FIDX_W-1:0] frame_index;
    logic                        evicted;
    logic [PAGE_W-1:0]           evicted_page;
  } plan_row_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  logic [PAGE_W-1:0]           page_number_i;
  logic                        cfg_we_i;
  logic [lpru_pkg::CFG_W-1:0]  cfg_wdata_i;
  logic                        done_o;
  logic                        hit_o;
  logic [lpru_pkg::FIDX_W-1:0] frame_index_o;
  logic                        evicted_o;
  logic [PAGE_W-1:0]           evicted_page_o;

  logic [PAGE_W-1:0]           held_page [FRAMES];
  logic [2:0]                  held_age [FRAMES];
  int unsigned                 held_count;
  logic [lpru_pkg::CFG_W-1:0]  frame_limit;

  ref_outcome_t                expected_outcomes [$];
  plan_row_t                   plan [PLAN_ROWS];
  logic                        pin_row;
  ref_outcome_t                pin_want;
  int unsigned                 words_taken;
  int unsigned                 mismatches;
  int unsigned                 quiet_cycles;

  lru_page_replacement_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .page_number_i  (page_number_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .frame_index_o  (frame_index_o),
    .evicted_o      (evicted_o),
    .evicted_page_o (evicted_page_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic ref_outcome_t resolve_reference(input logic [PAGE_W-1:0] page);
    ref_outcome_t res;
    int unsigned  cap;
    int unsigned  slot;
    int unsigned  i;
    logic         found;
    logic [2:0]   old_age;
    res   = '0;
    found = 1'b0;
    slot  = 0;
    if (frame_limit == 0) cap = 1;
    else if (frame_limit > FRAMES) cap = FRAMES;
    else cap = 32'(frame_limit);
    for (i = 0; i < held_count; i++) begin
      if (!found && held_page[i] == page) begin
        found = 1'b1;
        slot  = i;
      end
    end
    if (found) begin
      old_age = held_age[slot];
      for (i = 0; i < held_count; i++) begin
        if (held_age[i] < old_age) held_age[i] = held_age[i] + 3'd1;
      end
      held_age[slot] = '0;
      res.hit = 1'b1;
    end else if (held_count < cap) begin
      slot = held_count;
      for (i = 0; i < held_count; i++) held_age[i] = held_age[i] + 3'd1;
      held_page[slot] = page;
      held_age[slot]  = '0;
      held_count++;
    end else begin
      for (i = 1; i < held_count; i++) begin
        if (held_age[i] > held_age[slot]) slot = i;
      end
      res.evicted      = 1'b1;
      res.evicted_page = held_page[slot];
      for (i = 0; i < held_count; i++) begin
        if (i != slot) held_age[i] = held_age[i] + 3'd1;
      end
      held_page[slot] = page;
      held_age[slot]  = '0;
    end
    res.frame_index = slot[lpru_pkg::FIDX_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s at %0t: got %0h, want %0h", field, $time, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    ref_outcome_t want;
    if (rst_ni) begin
      if (cfg_we_i) frame_limit = cfg_wdata_i;
      if (done_o) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch("unexpected result", 32'd1, 32'd0);
        end else begin
          want = expected_outcomes.pop_front();
          if (hit_o !== want.hit)
            report_mismatch("hit", 32'(hit_o), 32'(want.hit));
          if (frame_index_o !== want.frame_index)
            report_mismatch("frame_index", 32'(frame_index_o), 32'(want.frame_index));
          if (evicted_o !== want.evicted)
            report_mismatch("evicted", 32'(evicted_o), 32'(want.evicted));
          if (evicted_page_o !== want.evicted_page)
            report_mismatch("evicted_page", 32'(evicted_page_o), 32'(want.evicted_page));
        end
      end
      if (start_i && !busy_o) begin
        want = resolve_reference(page_number_i);
        if (pin_row) want = pin_want;
        expected_outcomes.push_back(want);
        words_taken++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // hold the word until the unit takes it
  task automatic send_word(input logic [PAGE_W-1:0] page);
    int unsigned taken_before;
    taken_before  = words_taken;
    start_i       <= 1'b1;
    page_number_i <= page;
    do @(negedge clk_i); while (words_taken == taken_before);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (expected_outcomes.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [lpru_pkg::CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int unsigned row;
    int unsigned phase;
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    logic [PAGE_W-1:0] page;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    page_number_i = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    pin_row       = 1'b0;
    pin_want      = '0;
    words_taken   = 0;
    mismatches    = 0;
    quiet_cycles  = 0;
    held_count    = 0;
    frame_limit   = lpru_pkg::CFG_RESET;
    foreach (held_page[i]) begin
      held_page[i] = '0;
      held_age[i]  = '0;
    end
    plan = '{
      '{ROW_PAGE,  16'h0000, 1'b1, 1'b0, 3'd0, 1'b0, 16'h0000},
      '{ROW_PAGE,  16'hFFFF, 1'b1, 1'b0, 3'd1, 1'b0, 16'h0000},
      '{ROW_PAGE,  16'h0000, 1'b1, 1'b1, 3'd0, 1'b0, 16'h0000},
      '{ROW_LIMIT, 16'd2,    1'b0, 1'b0, 3'd0, 1'b0, 16'h0000},
      '{ROW_PAGE,  16'h8000, 1'b1, 1'b0, 3'd1, 1'b1, 16'hFFFF},
      '{ROW_LIMIT, 16'd0,    1'b0, 1'b0, 3'd0, 1'b0, 16'h0000},
      '{ROW_PAGE,  16'h0001, 1'b1, 1'b0, 3'd0, 1'b1, 16'h0000},
      '{ROW_PAGE,  16'h8000, 1'b1, 1'b1, 3'd1, 1'b0, 16'h0000},
      '{ROW_LIMIT, 16'd1,    1'b0, 1'b0, 3'd0, 1'b0, 16'h0000},
      '{ROW_PAGE,  16'h0002, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000},
      '{ROW_LIMIT, 16'd4,    1'b0, 1'b0, 3'd0, 1'b0, 16'h0000},
      '{ROW_PAGE,  16'h0003, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000},
      '{ROW_PAGE,  16'h0004, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000},
      '{ROW_PAGE,  16'h0005, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000},
      '{ROW_LIMIT, 16'd15,   1'b0, 1'b0, 3'd0, 1'b0, 16'h0000},
      '{ROW_PAGE,  16'h0010, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000},
      '{ROW_PAGE,  16'h0020, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000},
      '{ROW_PAGE,  16'h0040, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000},
      '{ROW_PAGE,  16'h0080, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000},
      '{ROW_PAGE,  16'h0100, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000},
      '{ROW_PAGE,  16'h7FFF, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000},
      '{ROW_LIMIT, 16'd3,    1'b0, 1'b0, 3'd0, 1'b0, 16'h0000},
      '{ROW_PAGE,  16'h0080, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000},
      '{ROW_PAGE,  16'hFFFF, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000}
    };

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (row = 0; row < PLAN_ROWS; row++) begin
      if (plan[row].kind == ROW_LIMIT) begin
        drain_results();
        write_limit(plan[row].value[lpru_pkg::CFG_W-1:0]);
      end else begin
        pin_row  = plan[row].pinned;
        pin_want = '{plan[row].hit, plan[row].frame_index, plan[row].evicted,
                     plan[row].evicted_page};
        send_word(plan[row].value);
      end
    end
    pin_row = 1'b0;

    for (phase = 0; phase < PHASES; phase++) begin
      drain_results();
      write_limit(lpru_pkg::CFG_W'($urandom_range(0, 15)));
      sent = 0;
      while (sent < PHASE_REFS) begin
        burst = $urandom_range(1, 16);
        repeat (burst) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: page = held_page[$urandom_range(0, held_count - 1)];
            4, 5, 6:    page = 16'h0100 + PAGE_W'($urandom_range(0, 11));
            default:    page = PAGE_W'($urandom);
          endcase
          send_word(page);
          sent++;
        end
        if ($urandom_range(0, 3) != 0) begin
          gap = $urandom_range(1, 14);
          start_i <= 1'b0;
          repeat (gap) begin
            page_number_i <= PAGE_W'($urandom);
            @(negedge clk_i);
          end
        end
      end
    end

    drain_results();
    repeat (FRAMES + 4) @(negedge clk_i);
    if (mismatches == 0 && expected_outcomes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
